// ===== rtl/rv32d_pkg.sv =====
// Shared opcodes, function codes, mnemonic codes and result type for the RV32 subset decoder.
package rv32d_pkg;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned IMM_W   = 21;
    localparam int unsigned TDATA_W = 48;

    localparam logic [6:0] OP_RTYPE  = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_ITYPE  = 7'h13;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6f;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_HALF = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [INSTR_W-1:0] ECALL_WORD = 32'h0000_0073;

    typedef enum logic [4:0] {
        MN_ADD, MN_MUL, MN_SUB, MN_SLL, MN_MULH, MN_SLT, MN_XOR, MN_DIV,
        MN_SRL, MN_SRA, MN_OR, MN_REM, MN_AND, MN_ADDI, MN_SLLI, MN_SLTI,
        MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI, MN_LB, MN_LH, MN_LW,
        MN_SB, MN_SH, MN_SW, MN_BEQ, MN_BNE, MN_LUI, MN_JAL, MN_ECALL
    } mnemonic_t;

    typedef struct packed {
        logic                    is_invalid;
        mnemonic_t               mnemonic;
        logic [REG_W-1:0]        dest_reg;
        logic [REG_W-1:0]        src1_reg;
        logic [REG_W-1:0]        src2_reg;
        logic signed [IMM_W-1:0] immediate;
    } result_t;

endpackage

// ===== rtl/rv32d_decode.sv =====
// Combinational decode of one instruction word into mnemonic, registers and immediate.
module rv32d_decode (
    input  logic [rv32d_pkg::INSTR_W-1:0] instr_word,
    output rv32d_pkg::result_t            result
);

    logic [6:0]                        op;
    logic [2:0]                        f3;
    logic [6:0]                        f7;
    logic [rv32d_pkg::REG_W-1:0]       rd;
    logic [rv32d_pkg::REG_W-1:0]       rs1;
    logic [rv32d_pkg::REG_W-1:0]       rs2;
    logic [rv32d_pkg::IMM_W-1:0]       imm_i;
    logic [rv32d_pkg::IMM_W-1:0]       imm_s;
    logic [rv32d_pkg::IMM_W-1:0]       imm_b;
    logic [rv32d_pkg::IMM_W-1:0]       imm_j;
    logic [rv32d_pkg::IMM_W-1:0]       imm_u;
    logic [rv32d_pkg::IMM_W-1:0]       imm_sh;
    logic                              ok;
    rv32d_pkg::mnemonic_t              code;
    logic [rv32d_pkg::REG_W-1:0]       d;
    logic [rv32d_pkg::REG_W-1:0]       s1;
    logic [rv32d_pkg::REG_W-1:0]       s2;
    logic [rv32d_pkg::IMM_W-1:0]       imm;

    assign op  = instr_word[6:0];
    assign rd  = instr_word[11:7];
    assign f3  = instr_word[14:12];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];
    assign f7  = instr_word[31:25];

    assign imm_i  = {{9{instr_word[31]}}, instr_word[31:20]};
    assign imm_s  = {{9{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b  = {{8{instr_word[31]}}, instr_word[31], instr_word[7],
                     instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j  = {instr_word[31], instr_word[19:12], instr_word[20],
                     instr_word[30:21], 1'b0};
    assign imm_u  = {1'b0, instr_word[31:12]};
    assign imm_sh = {11'b0, instr_word[29:20]};

    always_comb begin
        ok   = 1'b0;
        code = rv32d_pkg::MN_ADD;
        d    = '0;
        s1   = '0;
        s2   = '0;
        imm  = '0;
        case (op)
            rv32d_pkg::OP_RTYPE: begin
                d  = rd;
                s1 = rs1;
                s2 = rs2;
                case (f3)
                    rv32d_pkg::F3_ADD: begin
                        ok = 1'b1;
                        if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::MN_ADD;
                        else if (f7 == rv32d_pkg::F7_MULDIV) code = rv32d_pkg::MN_MUL;
                        else if (f7 == rv32d_pkg::F7_ALT) code = rv32d_pkg::MN_SUB;
                        else ok = 1'b0;
                    end
                    rv32d_pkg::F3_SLL: begin
                        ok = 1'b1;
                        if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::MN_SLL;
                        else if (f7 == rv32d_pkg::F7_MULDIV) code = rv32d_pkg::MN_MULH;
                        else ok = 1'b0;
                    end
                    rv32d_pkg::F3_SLT: begin
                        ok   = (f7 == rv32d_pkg::F7_BASE);
                        code = rv32d_pkg::MN_SLT;
                    end
                    rv32d_pkg::F3_XOR: begin
                        ok = 1'b1;
                        if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::MN_XOR;
                        else if (f7 == rv32d_pkg::F7_MULDIV) code = rv32d_pkg::MN_DIV;
                        else ok = 1'b0;
                    end
                    rv32d_pkg::F3_SR: begin
                        ok = 1'b1;
                        if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::MN_SRL;
                        else if (f7 == rv32d_pkg::F7_ALT) code = rv32d_pkg::MN_SRA;
                        else ok = 1'b0;
                    end
                    rv32d_pkg::F3_OR: begin
                        ok = 1'b1;
                        if (f7 == rv32d_pkg::F7_BASE) code = rv32d_pkg::MN_OR;
                        else if (f7 == rv32d_pkg::F7_MULDIV) code = rv32d_pkg::MN_REM;
                        else ok = 1'b0;
                    end
                    rv32d_pkg::F3_AND: begin
                        ok   = (f7 == rv32d_pkg::F7_BASE);
                        code = rv32d_pkg::MN_AND;
                    end
                    default: ok = 1'b0;
                endcase
            end
            rv32d_pkg::OP_ITYPE: begin
                d   = rd;
                s1  = rs1;
                imm = imm_i;
                ok  = 1'b1;
                case (f3)
                    rv32d_pkg::F3_ADD: code = rv32d_pkg::MN_ADDI;
                    rv32d_pkg::F3_SLL: begin
                        code = rv32d_pkg::MN_SLLI;
                        ok   = (f7 == rv32d_pkg::F7_BASE);
                    end
                    rv32d_pkg::F3_SLT: code = rv32d_pkg::MN_SLTI;
                    rv32d_pkg::F3_XOR: code = rv32d_pkg::MN_XORI;
                    rv32d_pkg::F3_SR: begin
                        if (f7 == rv32d_pkg::F7_BASE) begin
                            code = rv32d_pkg::MN_SRLI;
                        end else if (f7 == rv32d_pkg::F7_ALT) begin
                            code = rv32d_pkg::MN_SRAI;
                            imm  = imm_sh;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    rv32d_pkg::F3_OR:  code = rv32d_pkg::MN_ORI;
                    rv32d_pkg::F3_AND: code = rv32d_pkg::MN_ANDI;
                    default:           ok = 1'b0;
                endcase
            end
            rv32d_pkg::OP_LOAD: begin
                d   = rd;
                s1  = rs1;
                imm = imm_i;
                ok  = 1'b1;
                case (f3)
                    rv32d_pkg::F3_BYTE: code = rv32d_pkg::MN_LB;
                    rv32d_pkg::F3_HALF: code = rv32d_pkg::MN_LH;
                    rv32d_pkg::F3_WORD: code = rv32d_pkg::MN_LW;
                    default:            ok = 1'b0;
                endcase
            end
            rv32d_pkg::OP_STORE: begin
                s1  = rs1;
                s2  = rs2;
                imm = imm_s;
                ok  = 1'b1;
                case (f3)
                    rv32d_pkg::F3_BYTE: code = rv32d_pkg::MN_SB;
                    rv32d_pkg::F3_HALF: code = rv32d_pkg::MN_SH;
                    rv32d_pkg::F3_WORD: code = rv32d_pkg::MN_SW;
                    default:            ok = 1'b0;
                endcase
            end
            rv32d_pkg::OP_BRANCH: begin
                s1  = rs1;
                s2  = rs2;
                imm = imm_b;
                ok  = 1'b1;
                case (f3)
                    rv32d_pkg::F3_BEQ: code = rv32d_pkg::MN_BEQ;
                    rv32d_pkg::F3_BNE: code = rv32d_pkg::MN_BNE;
                    default:           ok = 1'b0;
                endcase
            end
            rv32d_pkg::OP_LUI: begin
                ok   = 1'b1;
                code = rv32d_pkg::MN_LUI;
                d    = rd;
                imm  = imm_u;
            end
            rv32d_pkg::OP_JAL: begin
                ok   = 1'b1;
                code = rv32d_pkg::MN_JAL;
                d    = rd;
                imm  = imm_j;
            end
            rv32d_pkg::OP_SYSTEM: begin
                ok   = (instr_word == rv32d_pkg::ECALL_WORD);
                code = rv32d_pkg::MN_ECALL;
            end
            default: ok = 1'b0;
        endcase

        result.is_invalid = 1'b0;
        result.mnemonic   = code;
        result.dest_reg   = d;
        result.src1_reg   = s1;
        result.src2_reg   = s2;
        result.immediate  = imm;
        if (!ok) begin
            result            = '0;
            result.is_invalid = 1'b1;
        end
    end

endmodule

// ===== rtl/rv32_subset_instruction_decoder.sv =====
// Top level: input request register, decode logic and result register with stream handshakes.
// A word is taken into the input register; its decoded result then moves to the result register.
// Throughput: one request per cycle while s_tready is high.
// s_tready drops only when both registers are full and m_tready is low.
// Reset (aresetn low, synchronous) empties both registers; payloads are not cleared.
module rv32_subset_instruction_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] instr_word
    input  logic [rv32d_pkg::INSTR_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] mnemonic, [9:5] dest_reg, [14:10] src1_reg, [19:15] src2_reg,
    // [40:20] immediate, [47:41] zero
    output logic [rv32d_pkg::TDATA_W-1:0]     m_tdata,
    // [0] is_invalid
    output logic                              m_tuser
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [rv32d_pkg::INSTR_W-1:0] in_word_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    rv32d_pkg::result_t            out_res_reg;
    rv32d_pkg::result_t            dec_res;
    logic                          advance;

    rv32d_decode u_decode (
        .instr_word (in_word_reg),
        .result     (dec_res)
    );

    assign advance        = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.is_invalid;
    assign m_tdata  = {7'b0, out_res_reg.immediate, out_res_reg.src2_reg,
                       out_res_reg.src1_reg, out_res_reg.dest_reg, out_res_reg.mnemonic};

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.is_invalid) |-> (m_tdata == '0))
        else $error("invalid result carries nonzero fields");

    a_fill_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("decoded request did not reach the result register");

    a_lui_regs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_res_reg.is_invalid && out_res_reg.mnemonic == rv32d_pkg::MN_LUI)
        |-> (out_res_reg.immediate[rv32d_pkg::IMM_W-1] == 1'b0 &&
             out_res_reg.src1_reg == '0 && out_res_reg.src2_reg == '0))
        else $error("lui result has sign bit or source registers set");

    a_store_branch_no_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_res_reg.is_invalid &&
         (out_res_reg.mnemonic == rv32d_pkg::MN_SB || out_res_reg.mnemonic == rv32d_pkg::MN_SH ||
          out_res_reg.mnemonic == rv32d_pkg::MN_SW || out_res_reg.mnemonic == rv32d_pkg::MN_BEQ ||
          out_res_reg.mnemonic == rv32d_pkg::MN_BNE))
        |-> (out_res_reg.dest_reg == '0))
        else $error("store or branch result has a destination register");

endmodule

// ===== bench/tb.sv =====
// Stream-level testbench for the RV32 subset instruction decoder with a self-checking scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32d_pkg::*;

    localparam int unsigned RANDOM_WORDS = 750;
    localparam int unsigned WATCHDOG     = 2000;

    class decode_tracker;
        result_t     pending_decodes[$];
        int unsigned errors;
        int unsigned decoded;
        int unsigned flagged;
        logic [31:0] seen_mnemonics;

        function new();
            errors         = 0;
            decoded        = 0;
            flagged        = 0;
            seen_mnemonics = '0;
        endfunction

        function result_t decode_word(logic [INSTR_W-1:0] w);
            result_t    r;
            mnemonic_t  mn;
            logic       ok;
            logic [6:0] op;
            logic [6:0] f7;
            logic [2:0] f3;
            logic [20:0] imm_i;
            logic [20:0] imm_s;
            logic [20:0] imm_b;
            logic [20:0] imm_j;
            op    = w[6:0];
            f3    = w[14:12];
            f7    = w[31:25];
            imm_i = {{9{w[31]}}, w[31:20]};
            imm_s = {{9{w[31]}}, w[31:25], w[11:7]};
            imm_b = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            imm_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};
            r  = '0;
            mn = MN_ADD;
            ok = 1'b1;
            case (op)
                OP_RTYPE: begin
                    r.dest_reg = w[11:7];
                    r.src1_reg = w[19:15];
                    r.src2_reg = w[24:20];
                    case (f3)
                        F3_ADD: begin
                            if (f7 == F7_BASE) mn = MN_ADD;
                            else if (f7 == F7_MULDIV) mn = MN_MUL;
                            else if (f7 == F7_ALT) mn = MN_SUB;
                            else ok = 1'b0;
                        end
                        F3_SLL: begin
                            if (f7 == F7_BASE) mn = MN_SLL;
                            else if (f7 == F7_MULDIV) mn = MN_MULH;
                            else ok = 1'b0;
                        end
                        F3_SLT: begin
                            if (f7 == F7_BASE) mn = MN_SLT;
                            else ok = 1'b0;
                        end
                        F3_XOR: begin
                            if (f7 == F7_BASE) mn = MN_XOR;
                            else if (f7 == F7_MULDIV) mn = MN_DIV;
                            else ok = 1'b0;
                        end
                        F3_SR: begin
                            if (f7 == F7_BASE) mn = MN_SRL;
                            else if (f7 == F7_ALT) mn = MN_SRA;
                            else ok = 1'b0;
                        end
                        F3_OR: begin
                            if (f7 == F7_BASE) mn = MN_OR;
                            else if (f7 == F7_MULDIV) mn = MN_REM;
                            else ok = 1'b0;
                        end
                        F3_AND: begin
                            if (f7 == F7_BASE) mn = MN_AND;
                            else ok = 1'b0;
                        end
                        default: ok = 1'b0;
                    endcase
                end
                OP_ITYPE: begin
                    r.dest_reg  = w[11:7];
                    r.src1_reg  = w[19:15];
                    r.immediate = imm_i;
                    case (f3)
                        F3_ADD: mn = MN_ADDI;
                        F3_SLL: begin
                            if (f7 == F7_BASE) mn = MN_SLLI;
                            else ok = 1'b0;
                        end
                        F3_SLT: mn = MN_SLTI;
                        F3_XOR: mn = MN_XORI;
                        F3_SR: begin
                            if (f7 == F7_BASE) begin
                                mn = MN_SRLI;
                            end else if (f7 == F7_ALT) begin
                                mn          = MN_SRAI;
                                r.immediate = {11'b0, w[29:20]};
                            end else begin
                                ok = 1'b0;
                            end
                        end
                        F3_OR:  mn = MN_ORI;
                        F3_AND: mn = MN_ANDI;
                        default: ok = 1'b0;
                    endcase
                end
                OP_LOAD: begin
                    r.dest_reg  = w[11:7];
                    r.src1_reg  = w[19:15];
                    r.immediate = imm_i;
                    case (f3)
                        F3_BYTE: mn = MN_LB;
                        F3_HALF: mn = MN_LH;
                        F3_WORD: mn = MN_LW;
                        default: ok = 1'b0;
                    endcase
                end
                OP_STORE: begin
                    r.src1_reg  = w[19:15];
                    r.src2_reg  = w[24:20];
                    r.immediate = imm_s;
                    case (f3)
                        F3_BYTE: mn = MN_SB;
                        F3_HALF: mn = MN_SH;
                        F3_WORD: mn = MN_SW;
                        default: ok = 1'b0;
                    endcase
                end
                OP_BRANCH: begin
                    r.src1_reg  = w[19:15];
                    r.src2_reg  = w[24:20];
                    r.immediate = imm_b;
                    case (f3)
                        F3_BEQ: mn = MN_BEQ;
                        F3_BNE: mn = MN_BNE;
                        default: ok = 1'b0;
                    endcase
                end
                OP_LUI: begin
                    mn          = MN_LUI;
                    r.dest_reg  = w[11:7];
                    r.immediate = {1'b0, w[31:12]};
                end
                OP_JAL: begin
                    mn          = MN_JAL;
                    r.dest_reg  = w[11:7];
                    r.immediate = imm_j;
                end
                OP_SYSTEM: begin
                    if (w == ECALL_WORD) mn = MN_ECALL;
                    else ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                r            = '0;
                r.is_invalid = 1'b1;
            end else begin
                r.mnemonic = mn;
            end
            return r;
        endfunction

        function void note_request(logic [INSTR_W-1:0] w);
            result_t r;
            r = decode_word(w);
            pending_decodes.push_back(r);
            decoded++;
            if (r.is_invalid) flagged++;
            else seen_mnemonics[r.mnemonic] = 1'b1;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] data, logic user);
            result_t e;
            if (pending_decodes.size() == 0) begin
                $error("result with no request pending: tdata 0x%0h tuser %0b", data, user);
                errors++;
                return;
            end
            e = pending_decodes.pop_front();
            compare("is_invalid", {31'b0, e.is_invalid}, {31'b0, user});
            compare("mnemonic", {27'b0, e.mnemonic}, {27'b0, data[4:0]});
            compare("dest_reg", {27'b0, e.dest_reg}, {27'b0, data[9:5]});
            compare("src1_reg", {27'b0, e.src1_reg}, {27'b0, data[14:10]});
            compare("src2_reg", {27'b0, e.src2_reg}, {27'b0, data[19:15]});
            compare("immediate", {11'b0, e.immediate}, {11'b0, data[40:20]});
            compare("pad", 32'b0, {25'b0, data[47:41]});
        endfunction

        function int unsigned pending_count();
            return pending_decodes.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [INSTR_W-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    decode_tracker track = new();
    int unsigned   burst_left  = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   rx_mode     = 0;
    int unsigned   rx_span     = 0;

    rv32_subset_instruction_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(20, 200);
        end
        rx_span--;
        case (rx_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) track.note_request(s_tdata);
            if (m_tvalid && m_tready) track.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG) begin
                    $display("tb: errors");
                    $finish;
                end
            end
        end
    end

    // Overlay opcode, and funct3/funct7 where used, onto the fill word; ECALL is its fixed word.
    function automatic logic [INSTR_W-1:0] encode_op(mnemonic_t mn, logic [INSTR_W-1:0] fill);
        logic [INSTR_W-1:0] w;
        logic [6:0]         op;
        logic [6:0]         f7;
        logic [2:0]         f3;
        logic               set_f3;
        logic               set_f7;
        op     = OP_RTYPE;
        f7     = F7_BASE;
        f3     = F3_ADD;
        set_f3 = 1'b1;
        set_f7 = 1'b0;
        case (mn)
            MN_ADD:   begin f3 = F3_ADD; set_f7 = 1'b1; end
            MN_MUL:   begin f3 = F3_ADD; f7 = F7_MULDIV; set_f7 = 1'b1; end
            MN_SUB:   begin f3 = F3_ADD; f7 = F7_ALT; set_f7 = 1'b1; end
            MN_SLL:   begin f3 = F3_SLL; set_f7 = 1'b1; end
            MN_MULH:  begin f3 = F3_SLL; f7 = F7_MULDIV; set_f7 = 1'b1; end
            MN_SLT:   begin f3 = F3_SLT; set_f7 = 1'b1; end
            MN_XOR:   begin f3 = F3_XOR; set_f7 = 1'b1; end
            MN_DIV:   begin f3 = F3_XOR; f7 = F7_MULDIV; set_f7 = 1'b1; end
            MN_SRL:   begin f3 = F3_SR; set_f7 = 1'b1; end
            MN_SRA:   begin f3 = F3_SR; f7 = F7_ALT; set_f7 = 1'b1; end
            MN_OR:    begin f3 = F3_OR; set_f7 = 1'b1; end
            MN_REM:   begin f3 = F3_OR; f7 = F7_MULDIV; set_f7 = 1'b1; end
            MN_AND:   begin f3 = F3_AND; set_f7 = 1'b1; end
            MN_ADDI:  begin op = OP_ITYPE; f3 = F3_ADD; end
            MN_SLLI:  begin op = OP_ITYPE; f3 = F3_SLL; set_f7 = 1'b1; end
            MN_SLTI:  begin op = OP_ITYPE; f3 = F3_SLT; end
            MN_XORI:  begin op = OP_ITYPE; f3 = F3_XOR; end
            MN_SRLI:  begin op = OP_ITYPE; f3 = F3_SR; set_f7 = 1'b1; end
            MN_SRAI:  begin op = OP_ITYPE; f3 = F3_SR; f7 = F7_ALT; set_f7 = 1'b1; end
            MN_ORI:   begin op = OP_ITYPE; f3 = F3_OR; end
            MN_ANDI:  begin op = OP_ITYPE; f3 = F3_AND; end
            MN_LB:    begin op = OP_LOAD; f3 = F3_BYTE; end
            MN_LH:    begin op = OP_LOAD; f3 = F3_HALF; end
            MN_LW:    begin op = OP_LOAD; f3 = F3_WORD; end
            MN_SB:    begin op = OP_STORE; f3 = F3_BYTE; end
            MN_SH:    begin op = OP_STORE; f3 = F3_HALF; end
            MN_SW:    begin op = OP_STORE; f3 = F3_WORD; end
            MN_BEQ:   begin op = OP_BRANCH; f3 = F3_BEQ; end
            MN_BNE:   begin op = OP_BRANCH; f3 = F3_BNE; end
            MN_LUI:   begin op = OP_LUI; set_f3 = 1'b0; end
            MN_JAL:   begin op = OP_JAL; set_f3 = 1'b0; end
            default:  begin op = OP_SYSTEM; end
        endcase
        if (mn == MN_ECALL) return ECALL_WORD;
        w      = fill;
        w[6:0] = op;
        if (set_f3) w[14:12] = f3;
        if (set_f7) w[31:25] = f7;
        return w;
    endfunction

    task automatic send_word(input logic [INSTR_W-1:0] w);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  = w;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin
        logic [INSTR_W-1:0] w;
        logic [INSTR_W-1:0] fill;
        int unsigned        pick;
        logic [4:0]         bit_pos;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int k = 0; k < 32; k++) begin
            send_word(encode_op(mnemonic_t'(k), (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000));
        end
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(encode_op(MN_SRAI, 32'hFFFF_FFFF));
        send_word(encode_op(MN_ECALL, '0) | 32'h0000_0080);
        send_word(encode_op(MN_ECALL, '0) | 32'h0010_0000);
        w = encode_op(MN_SLLI, 32'hFFFF_FFFF);
        w[31:25] = F7_ALT;
        send_word(w);
        w = encode_op(MN_SLT, $urandom);
        w[31:25] = F7_MULDIV;
        send_word(w);
        w = encode_op(MN_AND, $urandom);
        w[31:25] = F7_ALT;
        send_word(w);
        w = encode_op(MN_SLT, $urandom);
        w[14:12] = 3'd3;
        send_word(w);
        w = encode_op(MN_LB, $urandom);
        w[14:12] = 3'd4;
        send_word(w);
        w = encode_op(MN_BEQ, $urandom);
        w[14:12] = 3'd4;
        send_word(w);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) fill = 32'hFFFF_FFFF;
            else if (pick < 10) fill = 32'h0000_0000;
            else fill = $urandom;
            w = encode_op(mnemonic_t'($urandom_range(0, 31)), fill);
            pick = $urandom_range(0, 99);
            if (pick >= 85) begin
                w = $urandom;
            end else if (pick >= 70) begin
                bit_pos = 5'($urandom_range(0, 31));
                w[bit_pos] = ~w[bit_pos];
            end
            send_word(w);
        end
        s_tvalid = 1'b0;

        while (track.pending_count() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        $display("tb: %0d instruction words decoded, %0d of them flagged invalid",
                 track.decoded, track.flagged);
        $display("tb: %0d of 32 mnemonics produced, %0d field mismatches",
                 $countones(track.seen_mnemonics), track.errors);
        if (track.errors == 0 && track.pending_count() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
